// ===== src/sha256bsh_pkg.sv =====
// Shared SHA-256 constants, types and round functions for the byte-stream hasher.
package sha256bsh_pkg;

    typedef enum logic
    {
        OP_ABSORB = 1'b0,
        OP_FINISH = 1'b1
    } opcode_t;

    localparam logic [7:0] PAD_BYTE  = 8'h80;
    localparam logic [5:0] LEN_START = 6'd56;   // first byte slot of the bit length

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] ch(input logic [31:0] e, input logic [31:0] f,
                                       input logic [31:0] g);
        return (e & f) ^ (~e & g);
    endfunction

    function automatic logic [31:0] maj(input logic [31:0] a, input logic [31:0] b,
                                        input logic [31:0] c);
        return (a & b) ^ (a & c) ^ (b & c);
    endfunction

endpackage

// ===== src/sha256_byte_stream_hasher_core.sv =====
// SHA-256 byte-stream hasher: byte absorb, padding sequencer, one round per cycle.
//
//  channel | signals                                          | direction
//  --------+--------------------------------------------------+----------
//  in      | in_valid, in_stall, opcode, data_byte            | into block
//  out     | out_valid, out_stall, digest_word, word_pos,     | out of block
//          | last_word, length_error                          |
//
// An absorb word shifts in its byte; when it completes a 64-byte block,
// the block runs 64 rounds of the shared round unit, then the hash add.
// A finish word shifts in padding one byte per cycle up to the block end,
// then one compression, and a second pad pass plus compression when more
// than 55 bytes were buffered; then 8 digest words.
// Reset clears the sequencer, counters and loads the initial hash values.
// in_stall is high whenever the sequencer is not idle; out_stall holds the
// current digest word in place until taken.
module sha256_byte_stream_hasher_core
    import sha256bsh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [0:0]  opcode,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_pos,
    output logic        last_word,
    output logic        length_error
);

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_ADD,
        ST_OUT
    } state_t;

    state_t      state_reg, state_next;
    logic [31:0] hash_reg [8];
    logic [31:0] hash_next [8];
    logic [31:0] win_reg [16];      // block bytes, then rolling schedule window
    logic [31:0] win_next [16];
    logic [31:0] work_reg [8];      // a..h
    logic [31:0] work_next [8];
    logic [5:0]  fill_reg, fill_next;
    logic [5:0]  rnd_reg, rnd_next;
    logic [60:0] count_reg, count_next;   // bytes; overflow flag covers the rest
    logic        ovf_reg, ovf_next;
    logic        fin_reg, fin_next;       // finishing a message
    logic        len_blk_reg, len_blk_next; // current pad block carries the length
    logic        first_reg, first_next;   // next pad byte is the 0x80 marker
    logic        err_reg, err_next;
    logic [2:0]  idx_reg, idx_next;

    logic             in_accept;
    logic             shift_en;
    logic [7:0]       shift_byte;
    logic [7:0][7:0]  len_bytes;
    logic [31:0]      w_new;
    logic [31:0]      t1;
    logic [31:0]      t2;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;

    assign out_valid    = (state_reg == ST_OUT);
    assign digest_word  = err_reg ? 32'd0 : hash_reg[idx_reg];
    assign word_pos     = idx_reg;
    assign last_word    = err_reg || (idx_reg == 3'd7);
    assign length_error = err_reg;

    // Bit length, big-endian bytes; index 7 is the most significant.
    assign len_bytes = {count_reg, 3'b000};

    // Shared round unit: schedule word and the two temporaries.
    assign w_new = small_sigma1(win_reg[14]) + win_reg[9]
                 + small_sigma0(win_reg[1]) + win_reg[0];
    assign t1 = work_reg[7] + big_sigma1(work_reg[4])
              + ch(work_reg[4], work_reg[5], work_reg[6])
              + ROUND_K[rnd_reg] + win_reg[0];
    assign t2 = big_sigma0(work_reg[0]) + maj(work_reg[0], work_reg[1], work_reg[2]);

    always_comb
    begin
        state_next   = state_reg;
        hash_next    = hash_reg;
        win_next     = win_reg;
        work_next    = work_reg;
        fill_next    = fill_reg;
        rnd_next     = rnd_reg;
        count_next   = count_reg;
        ovf_next     = ovf_reg;
        fin_next     = fin_reg;
        len_blk_next = len_blk_reg;
        first_next   = first_reg;
        err_next     = err_reg;
        idx_next     = idx_reg;
        shift_en     = 1'b0;
        shift_byte   = data_byte;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (opcode_t'(opcode) == OP_ABSORB)
                    begin
                        shift_en   = 1'b1;
                        count_next = count_reg + 61'd1;
                        if (count_reg == '1)
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                    else if (ovf_reg)
                    begin
                        err_next   = 1'b1;
                        idx_next   = 3'd0;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        fin_next     = 1'b1;
                        first_next   = 1'b1;
                        len_blk_next = (fill_reg < LEN_START);
                        state_next   = ST_PAD;
                    end
                end
            end

            ST_PAD:
            begin
                shift_en   = 1'b1;
                first_next = 1'b0;
                if (first_reg)
                begin
                    shift_byte = PAD_BYTE;
                end
                else if (len_blk_reg && (fill_reg >= LEN_START))
                begin
                    shift_byte = len_bytes[3'(~fill_reg[2:0])];
                end
                else
                begin
                    shift_byte = 8'd0;
                end
            end

            ST_ROUND:
            begin
                for (int i = 0; i < 15; i++)
                begin
                    win_next[i] = win_reg[i + 1];
                end
                win_next[15] = w_new;
                work_next[7] = work_reg[6];
                work_next[6] = work_reg[5];
                work_next[5] = work_reg[4];
                work_next[4] = work_reg[3] + t1;
                work_next[3] = work_reg[2];
                work_next[2] = work_reg[1];
                work_next[1] = work_reg[0];
                work_next[0] = t1 + t2;
                rnd_next     = rnd_reg + 6'd1;
                if (rnd_reg == 6'd63)
                begin
                    state_next = ST_ADD;
                end
            end

            ST_ADD:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    hash_next[i] = hash_reg[i] + work_reg[i];
                end
                priority if (!fin_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (len_blk_reg)
                begin
                    idx_next   = 3'd0;
                    err_next   = 1'b0;
                    state_next = ST_OUT;
                end
                else
                begin
                    len_blk_next = 1'b1;
                    state_next   = ST_PAD;
                end
            end

            ST_OUT:
            begin
                if (!out_stall)
                begin
                    if (last_word)
                    begin
                        // back to the fresh-message state
                        hash_next  = INIT_H;
                        fill_next  = 6'd0;
                        count_next = '0;
                        ovf_next   = 1'b0;
                        fin_next   = 1'b0;
                        err_next   = 1'b0;
                        idx_next   = 3'd0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Byte shift into the block; a full block starts the compression.
        if (shift_en)
        begin
            for (int i = 0; i < 15; i++)
            begin
                win_next[i] = {win_reg[i][23:0], win_reg[i + 1][31:24]};
            end
            win_next[15] = {win_reg[15][23:0], shift_byte};
            fill_next    = fill_reg + 6'd1;
            if (fill_reg == 6'd63)
            begin
                work_next  = hash_reg;
                rnd_next   = 6'd0;
                state_next = ST_ROUND;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            hash_reg    <= INIT_H;
            fill_reg    <= 6'd0;
            rnd_reg     <= 6'd0;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            fin_reg     <= 1'b0;
            len_blk_reg <= 1'b0;
            first_reg   <= 1'b0;
            err_reg     <= 1'b0;
            idx_reg     <= 3'd0;
        end
        else
        begin
            state_reg   <= state_next;
            hash_reg    <= hash_next;
            fill_reg    <= fill_next;
            rnd_reg     <= rnd_next;
            count_reg   <= count_next;
            ovf_reg     <= ovf_next;
            fin_reg     <= fin_next;
            len_blk_reg <= len_blk_next;
            first_reg   <= first_next;
            err_reg     <= err_next;
            idx_reg     <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg  <= win_next;
        work_reg <= work_next;
    end

endmodule

// ===== bench/sha256_digest_checker.sv =====
// Digest checker: predicts SHA-256 digest words from accepted input words and compares them.
`timescale 1ns / 1ps

module sha256_digest_checker
    import sha256bsh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [0:0]  opcode,
    input  logic [7:0]  data_byte,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [31:0] digest_word,
    input  logic [2:0]  word_pos,
    input  logic        last_word,
    input  logic        length_error,
    output int          fail_count,
    output int          pending_words
);

    localparam logic [63:0] MAX_MSG_BYTES = 64'h1FFF_FFFF_FFFF_FFFF;

    localparam logic [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] SHA_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef struct packed
    {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
        logic        err;
    } digest_entry_t;

    digest_entry_t expected_words [$];

    logic [31:0] chain_hash [8];
    logic [7:0]  block_bytes [64];
    int          block_fill;
    logic [63:0] msg_bytes;
    logic        msg_overflow;

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        logic [63:0] doubled;
        doubled = {x, x} >> n;
        return doubled[31:0];
    endfunction

    function automatic void compress_block_bytes();
        logic [31:0] sched [16];
        logic [31:0] v [8];
        logic [31:0] wr;
        logic [31:0] w2;
        logic [31:0] w15;
        logic [31:0] t1;
        logic [31:0] t2;
        for (int j = 0; j < 16; j++)
        begin
            sched[j] = {block_bytes[4*j], block_bytes[4*j+1],
                        block_bytes[4*j+2], block_bytes[4*j+3]};
        end
        for (int j = 0; j < 8; j++)
        begin
            v[j] = chain_hash[j];
        end
        for (int r = 0; r < 64; r++)
        begin
            if (r < 16)
            begin
                wr = sched[r];
            end
            else
            begin
                w2  = sched[(r - 2) % 16];
                w15 = sched[(r - 15) % 16];
                wr  = (ror32(w2, 17) ^ ror32(w2, 19) ^ (w2 >> 10)) + sched[(r - 7) % 16]
                    + (ror32(w15, 7) ^ ror32(w15, 18) ^ (w15 >> 3)) + sched[r % 16];
                sched[r % 16] = wr;
            end
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[r] + wr;
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int j = 0; j < 8; j++)
        begin
            chain_hash[j] = chain_hash[j] + v[j];
        end
    endfunction

    function automatic void clear_message();
        for (int j = 0; j < 8; j++)
        begin
            chain_hash[j] = SHA_IV[j];
        end
        for (int j = 0; j < 64; j++)
        begin
            block_bytes[j] = 8'h00;
        end
        block_fill   = 0;
        msg_bytes    = 64'd0;
        msg_overflow = 1'b0;
    endfunction

    function automatic void absorb_byte(input logic [7:0] b);
        if (msg_bytes != '1)
        begin
            msg_bytes = msg_bytes + 64'd1;
        end
        if (msg_bytes > MAX_MSG_BYTES)
        begin
            msg_overflow = 1'b1;
        end
        block_bytes[block_fill] = b;
        block_fill++;
        if (block_fill == 64)
        begin
            compress_block_bytes();
            block_fill = 0;
        end
    endfunction

    function automatic void finish_digest();
        logic [63:0]   bit_len;
        digest_entry_t ent;
        if (msg_overflow || msg_bytes > MAX_MSG_BYTES)
        begin
            ent = '{word: 32'd0, index: 3'd0, last: 1'b1, err: 1'b1};
            expected_words = {expected_words, ent};
        end
        else
        begin
            bit_len = msg_bytes << 3;
            block_bytes[block_fill] = 8'h80;
            block_fill++;
            // no room left for the length: flush a zero-padded block first
            if (block_fill > 56)
            begin
                for (int j = block_fill; j < 64; j++)
                begin
                    block_bytes[j] = 8'h00;
                end
                compress_block_bytes();
                block_fill = 0;
            end
            for (int j = block_fill; j < 56; j++)
            begin
                block_bytes[j] = 8'h00;
            end
            for (int j = 0; j < 8; j++)
            begin
                block_bytes[56 + j] = bit_len[(7 - j) * 8 +: 8];
            end
            compress_block_bytes();
            for (int j = 0; j < 8; j++)
            begin
                ent = '{word: chain_hash[j], index: 3'(j), last: (j == 7), err: 1'b0};
                expected_words = {expected_words, ent};
            end
        end
        clear_message();
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        digest_entry_t got;
        digest_entry_t want;
        if (!rst_n)
        begin
            clear_message();
            expected_words.delete();
            fail_count    <= 0;
            pending_words <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                if (opcode_t'(opcode) == OP_FINISH)
                begin
                    finish_digest();
                end
                else
                begin
                    absorb_byte(data_byte);
                end
            end
            if (out_valid && !out_stall)
            begin
                got = '{word: digest_word, index: word_pos, last: last_word,
                        err: length_error};
                if (expected_words.size() == 0)
                begin
                    if (fail_count < 10)
                    begin
                        $display("%0t: unexpected digest word %h idx %0d last %b err %b",
                                 $realtime, got.word, got.index, got.last, got.err);
                    end
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (got !== want)
                    begin
                        if (fail_count < 10)
                        begin
                            $display("%0t: digest mismatch exp %h/%0d/%b/%b got %h/%0d/%b/%b",
                                     $realtime, want.word, want.index, want.last, want.err,
                                     got.word, got.index, got.last, got.err);
                        end
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending_words <= expected_words.size();
        end
    end

endmodule

// ===== bench/tb.sv =====
// Top of the SHA-256 byte-stream hasher bench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb
    import sha256bsh_pkg::*;
;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [0:0]  opcode;
    logic [7:0]  data_byte;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] digest_word;
    logic [2:0]  word_pos;
    logic        last_word;
    logic        length_error;

    int fail_count;
    int pending_words;

    // Idle rates (percent per cycle) of the sender and the receiver; the
    // stimulus moves them through four phases as the word count grows.
    int send_idle_pct;
    int recv_stall_pct;
    int words_sent;

    sha256_byte_stream_hasher_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .data_byte    (data_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .digest_word  (digest_word),
        .word_pos     (word_pos),
        .last_word    (last_word),
        .length_error (length_error)
    );

    sha256_digest_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .data_byte     (data_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .digest_word   (digest_word),
        .word_pos      (word_pos),
        .last_word     (last_word),
        .length_error  (length_error),
        .fail_count    (fail_count),
        .pending_words (pending_words)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Hard stop in case the block hangs somewhere (stuck stall, lost words).
    initial
    begin
        #3_000_000;
        $display("** sha256_byte_stream_hasher_core: FAILED **");
        $finish;
    end

    // Receiver back-pressure, redrawn every falling edge at the phase rate.
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Phase plan by words sent: free-running, sender gaps, receiver stalls,
    // then both at a lighter rate.
    function automatic void set_phase();
        unique case (words_sent / 115)
            0:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            1:
            begin
                send_idle_pct  = 46;
                recv_stall_pct = 0;
            end
            2:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 46;
            end
            default:
            begin
                send_idle_pct  = 20;
                recv_stall_pct = 20;
            end
        endcase
    endfunction

    // Present one word at the falling edge and hold it until the block takes
    // it. Returns on the falling edge after acceptance, valid still high, so
    // a following word goes out with no bubble.
    task automatic send_word(input opcode_t op, input logic [7:0] b);
        set_phase();
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid  <= 1'b0;
            data_byte <= 8'($urandom);
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        opcode    <= op;
        data_byte <= b;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        words_sent++;
        @(negedge clk);
    endtask

    // A whole message of random bytes; the finish carries a junk byte that
    // the block must ignore.
    task automatic send_random_message(input int len);
        for (int i = 0; i < len; i++)
        begin
            send_word(OP_ABSORB, 8'($urandom));
        end
        send_word(OP_FINISH, 8'($urandom));
    endtask

    // Message length mix: mostly short, a share right at the padding and
    // block boundaries, the rest spread over one to two blocks.
    function automatic int pick_length();
        int sel;
        int edge_lens [7];
        edge_lens = '{54, 55, 56, 57, 63, 64, 65};
        sel = $urandom_range(99);
        if (sel < 50)
        begin
            return $urandom_range(10);
        end
        else if (sel < 75)
        begin
            return edge_lens[$urandom_range(6)];
        end
        return $urandom_range(80);
    endfunction

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        opcode         = OP_ABSORB;
        data_byte      = 8'h00;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        words_sent     = 0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: empty message, single extreme bytes, "abc", high/low bit
        // mix, and a finish right after a finish.
        send_word(OP_FINISH, 8'hff);
        send_word(OP_ABSORB, 8'h00);
        send_word(OP_FINISH, 8'h00);
        send_word(OP_ABSORB, 8'hff);
        send_word(OP_FINISH, 8'hff);
        send_word(OP_ABSORB, 8'h61);
        send_word(OP_ABSORB, 8'h62);
        send_word(OP_ABSORB, 8'h63);
        send_word(OP_FINISH, 8'h00);
        send_word(OP_ABSORB, 8'h80);
        send_word(OP_ABSORB, 8'h7f);
        send_word(OP_FINISH, 8'h55);
        send_word(OP_FINISH, 8'haa);

        // Padding split points first: length fits the last block exactly,
        // just spills into an extra block, and a full block before padding.
        send_random_message(55);
        send_random_message(56);
        send_random_message(64);

        while (words_sent < 460)
        begin
            send_random_message(pick_length());
        end
        in_valid <= 1'b0;

        // Drain: every predicted digest word has to come out, then a quiet
        // tail longer than a full pad + compression pass to catch extras.
        for (int i = 0; i < 20000 && pending_words != 0; i++)
        begin
            @(posedge clk);
        end
        repeat (300) @(posedge clk);

        if (fail_count == 0 && pending_words == 0)
        begin
            $display("** sha256_byte_stream_hasher_core: PASSED **");
        end
        else
        begin
            $display("** sha256_byte_stream_hasher_core: FAILED **");
        end
        $finish;
    end

endmodule
